/* rtl/assert_macros.svh */
// assertion helpers included by floppy_track_bitcell_writer
// both sample on the rising edge of clk and are off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication within the same cycle or any property text
`define FTBW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define FTBW_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg_next_default);

`endif

/* rtl/ftbw_pkg.sv */
// ----------------------------------------------------------------------------
// ftbw_pkg
// Types, constants and small helper functions of the floppy track bit-cell
// writer: request layouts, register indexes, header bytes, FM spreading.
// ----------------------------------------------------------------------------
package ftbw_pkg;

  // geometry and length limits
  localparam int MAX_CYLINDERS    = 81;
  localparam int BASE_TRACK_WORDS = 3190;
  localparam int BASE_BLOCKS      = 50;
  localparam int AREA_OFFSET      = 1024;

  // widths of internal state
  localparam int POS_W  = 16;
  localparam int WORD_W = 14;
  localparam int BASE_W = 23;
  localparam int ADDR_W = 22;
  localparam int CYL_W  = $clog2(MAX_CYLINDERS);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MFM_MODE     = 2'd0,
    REG_HIGH_DENSITY = 2'd1,
    REG_DOUBLE_SIDED = 2'd2
  } reg_index_t;

  // input request
  typedef struct packed {
    logic        op;
    logic [7:0]  track_number;
    logic [15:0] pulse_word;
  } in_item_t;

  // output request
  typedef struct packed {
    logic [7:0]        image_byte;
    logic [ADDR_W-1:0] image_address;
    logic              last;
  } out_item_t;

  // op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_PULSE = 1'b1;

  // bit order swap within a byte
  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // each data bit onto an odd position, clock bits left zero
  function automatic logic [15:0] fm_spread(input logic [7:0] v);
    logic [15:0] r;
    r = '0;
    r[9]  = v[7];
    r[11] = v[6];
    r[13] = v[5];
    r[15] = v[4];
    r[1]  = v[3];
    r[3]  = v[2];
    r[5]  = v[1];
    r[7]  = v[0];
    return r;
  endfunction

  // next byte position of one side, skipping the other side's 256 bytes
  function automatic logic [POS_W-1:0] pos_step(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] q;
    q = p + POS_W'(1);
    if (q[7:0] == 8'h00) begin
      q = q + POS_W'(256);
    end
    return q;
  endfunction

  // track header bytes as stored in the image
  localparam logic [7:0] HDR_BYTE_A = 8'hF1;
  localparam logic [7:0] HDR_BYTE_B = 8'hF2;
  localparam logic [7:0] HDR_BYTE_C = 8'd72;
  localparam logic [7:0] HDR_OUT_A  = reverse8(HDR_BYTE_A);
  localparam logic [7:0] HDR_OUT_B  = reverse8(HDR_BYTE_B);
  localparam logic [7:0] HDR_OUT_C  = reverse8(HDR_BYTE_C);

endpackage

/* rtl/floppy_track_bitcell_writer.sv */
// ----------------------------------------------------------------------------
// floppy_track_bitcell_writer
// Turns start-track and pulse-word requests into addressed image bytes of an
// interleaved two-side track image, one byte per output request.
// ----------------------------------------------------------------------------
// A request is decoded in the cycle it is accepted into a burst register of
// up to four bytes, which then drains one byte per cycle into the output
// register while the output is not stalled. The output channel moves one byte
// per cycle when out_ready holds; a start-track request gives 3 bytes, an
// MFM pulse word 2 and an FM pulse word 4, and a word past the track length
// limit gives nothing. The next request is taken in the cycle the last byte of
// the burst leaves, and the first byte of a request goes from the burst
// register into the output register once the output is not stalled.
module floppy_track_bitcell_writer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ftbw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ftbw_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data
);
  import ftbw_pkg::*;

`include "assert_macros.svh"

  // configuration
  logic mfm_mode;
  logic high_density;
  logic double_sided;

  // track state
  logic [POS_W-1:0]  side_position;
  logic [WORD_W-1:0] words_taken;
  logic [BASE_W-1:0] track_base;

  // burst register
  logic                burst_valid;
  logic [2:0]          burst_left;
  logic [3:0][7:0]     burst_bytes;
  logic [POS_W-1:0]    burst_pos;
  logic [BASE_W-1:0]   burst_base;

  // decode of the incoming request
  logic              in_take;
  logic              move;
  logic              load;
  logic              drop;
  logic [7:0]        cyl_raw;
  logic [CYL_W-1:0]  cyl_sat;
  logic              side;
  logic [BASE_W-1:0] blk_prod;
  logic [BASE_W-1:0] base_next;
  logic [WORD_W-1:0] word_limit;
  logic [15:0]       spread_hi;
  logic [15:0]       spread_lo;
  logic [3:0][7:0]   load_bytes;
  logic [2:0]        load_count;
  logic [POS_W-1:0]  load_pos;
  logic [POS_W-1:0]  pos_1;
  logic [POS_W-1:0]  pos_2;
  logic [POS_W-1:0]  pos_3;
  logic [POS_W-1:0]  pos_4;
  logic [POS_W-1:0]  side_position_next;

  localparam string msg_next_default = "ftbw: sequence check failed";

  // handshake
  assign move     = burst_valid && (!out_valid || out_ready);
  assign in_ready = !burst_valid || (move && (burst_left == 3'd1));
  assign in_take  = in_valid && in_ready;

  // cylinder, side and track base of a start request
  always_comb begin
    cyl_raw = in_data.track_number;
    side    = 1'b0;
    if (double_sided) begin
      cyl_raw = {1'b0, in_data.track_number[7:1]};
      side    = in_data.track_number[0];
    end
    if (cyl_raw >= 8'(MAX_CYLINDERS)) begin
      cyl_sat = CYL_W'(MAX_CYLINDERS - 1);
    end else begin
      cyl_sat = cyl_raw[CYL_W-1:0];
    end
    blk_prod  = BASE_W'(cyl_sat) * BASE_W'(BASE_BLOCKS);
    base_next = BASE_W'(AREA_OFFSET)
              + (high_density ? (blk_prod << 10) : (blk_prod << 9))
              + (side ? BASE_W'(256) : BASE_W'(0));
  end

  // track length limit in words
  always_comb begin
    case ({mfm_mode, high_density})
      2'b00:   word_limit = WORD_W'(BASE_TRACK_WORDS);
      2'b01,
      2'b10:   word_limit = WORD_W'(BASE_TRACK_WORDS * 2);
      2'b11:   word_limit = WORD_W'(BASE_TRACK_WORDS * 4);
      default: word_limit = WORD_W'(BASE_TRACK_WORDS);
    endcase
  end

  // byte content of the burst
  assign spread_hi = fm_spread(in_data.pulse_word[15:8]);
  assign spread_lo = fm_spread(in_data.pulse_word[7:0]);

  always_comb begin
    drop       = 1'b0;
    load_bytes = '0;
    load_count = 3'd0;
    load_pos   = side_position;
    if (in_data.op == OP_START) begin
      load_bytes = {8'h00, HDR_OUT_C, HDR_OUT_B, HDR_OUT_A};
      load_count = 3'd3;
      load_pos   = '0;
    end else begin
      drop = (words_taken >= word_limit);
      if (mfm_mode) begin
        load_bytes = {8'h00, 8'h00, reverse8(in_data.pulse_word[7:0]),
                      reverse8(in_data.pulse_word[15:8])};
        load_count = 3'd2;
      end else begin
        load_bytes = {spread_lo[7:0], spread_lo[15:8],
                      spread_hi[7:0], spread_hi[15:8]};
        load_count = 3'd4;
      end
    end
  end

  assign load = in_take && !drop;

  // position after the burst has drained
  assign pos_1 = pos_step(load_pos);
  assign pos_2 = pos_step(pos_1);
  assign pos_3 = pos_step(pos_2);
  assign pos_4 = pos_step(pos_3);

  always_comb begin
    case (load_count)
      3'd2:    side_position_next = pos_2;
      3'd3:    side_position_next = pos_3;
      3'd4:    side_position_next = pos_4;
      default: side_position_next = load_pos;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mfm_mode     <= 1'b0;
      high_density <= 1'b0;
      double_sided <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MFM_MODE:     mfm_mode     <= cfg_data;
        REG_HIGH_DENSITY: high_density <= cfg_data;
        REG_DOUBLE_SIDED: double_sided <= cfg_data;
        default:          ;
      endcase
    end
  end

  // track state update
  always_ff @(posedge clk) begin
    if (rst) begin
      side_position <= '0;
      words_taken   <= '0;
      track_base    <= BASE_W'(AREA_OFFSET);
    end else if (load) begin
      side_position <= side_position_next;
      if (in_data.op == OP_START) begin
        words_taken <= '0;
        track_base  <= base_next;
      end else begin
        words_taken <= words_taken + WORD_W'(1);
      end
    end
  end

  // burst register: load a request or shift out one byte
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      burst_left  <= 3'd0;
    end else if (load) begin
      burst_valid <= 1'b1;
      burst_left  <= load_count;
    end else if (move) begin
      burst_valid <= (burst_left != 3'd1);
      burst_left  <= burst_left - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_bytes <= load_bytes;
      burst_pos   <= load_pos;
      burst_base  <= (in_data.op == OP_START) ? base_next : track_base;
    end else if (move) begin
      burst_bytes <= {8'h00, burst_bytes[3:1]};
      burst_pos   <= pos_step(burst_pos);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data.image_byte    <= burst_bytes[0];
      out_data.image_address <= ADDR_W'(burst_base + BASE_W'(burst_pos));
      out_data.last          <= (burst_left == 3'd1);
    end
  end

  // a new request only enters when no burst is pending or the previous burst is on its last byte
  `FTBW_ASSERT(a_no_overrun, in_take |-> (!burst_valid || (move && burst_left == 3'd1)), "ftbw: request taken over a pending burst")
  // a loaded burst always holds between one and four bytes
  `FTBW_ASSERT(a_burst_count, burst_valid |-> (burst_left != 3'd0 && burst_left <= 3'd4), "ftbw: burst count out of range")
  // the final byte of a burst carries the last mark
  `FTBW_ASSERT_NEXT(a_last_mark, move && burst_left == 3'd1, out_valid && out_data.last)
  // a start request or a word within the limit always starts a burst
  `FTBW_ASSERT_NEXT(a_load_burst, load, burst_valid)

endmodule
